FILE: rtl/sro_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sro_pkg
// Shared constants and types for the sample ring overrun tracker.
// ----------------------------------------------------------------------------
package sro_pkg;

  localparam int unsigned RING_DEPTH = 512;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned AVAIL_W    = $clog2(RING_DEPTH + 1);
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned REM_W      = 16;
  localparam int unsigned AGE_W      = REM_W + PERIOD_W;

  typedef logic [1:0]          req_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [REM_W-1:0]    rem_t;
  typedef logic [AVAIL_W-1:0]  avail_t;

  localparam req_t REQ_SAMPLE = 2'd0;
  localparam req_t REQ_READ   = 2'd1;
  localparam req_t REQ_POLL   = 2'd2;
  localparam req_t REQ_CLEAR  = 2'd3;

  localparam period_t PERIOD_RESET = 8'd4;

endpackage
`default_nettype wire

FILE: rtl/sample_ring_overrun_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_ring_overrun_tracker
// Overwriting sample ring with a tracked consumer, overrun flag and
// back-dated read timestamps.
// ----------------------------------------------------------------------------
// sample and clear requests complete in the accept cycle: one per cycle.
// read and poll requests update the produced count at accept, then hold busy
// through overrun base, overrun skip, ring memory read and result assembly;
// done pulses after result assembly, and no new request is taken before then.
// the receiver cannot stall done. synchronous reset clears pointers, counts,
// flag and period (to 4); the ring memory holds no reset value.
module sample_ring_overrun_tracker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire sro_pkg::req_t    req_type,
  input  wire sro_pkg::sample_t adc_sample,
  input  wire sro_pkg::cnt_t    now_ms,
  input  wire sro_pkg::rem_t    batch_left,
  input  wire logic             cfg_we,
  input  wire sro_pkg::period_t cfg_wdata,
  output logic                  done,
  output logic                  ok,
  output sro_pkg::sample_t      sample_value,
  output sro_pkg::cnt_t         sample_time_ms,
  output sro_pkg::avail_t       avail_count,
  output sro_pkg::ptr_t         write_index,
  output logic                  overflow
);
  import sro_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state;
  ptr_t       producer_ptr;
  ptr_t       seen_ptr;
  ptr_t       consumer_ptr;
  cnt_t       produced_count;
  cnt_t       consumed_count;
  logic       overrun_flag;
  period_t    period;

  req_t              req_q;
  cnt_t              now_q;
  logic [AGE_W-1:0]  age_q;
  cnt_t              cmp_base;
  logic              have_data;
  cnt_t              ts_q;

  sample_t ring_mem [RING_DEPTH];
  sample_t ring_rdata;
  logic    mem_we;
  logic    mem_re;

  logic              accept;
  ptr_t              ptr_delta;
  rem_t              rem_m1;
  logic [AGE_W-1:0]  age_calc;
  cnt_t              lost;
  logic              skip;
  logic              can_read;
  cnt_t              diff;
  avail_t            unread;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (req_type == REQ_SAMPLE);
  assign mem_re = (state == S_READ);

  // wrapped distance, ring depth is a power of two
  assign ptr_delta = producer_ptr - seen_ptr;
  assign rem_m1    = batch_left - rem_t'(1);
  assign age_calc  = (batch_left == '0) ? '0
                     : AGE_W'(rem_m1) * AGE_W'(period);

  assign skip     = (produced_count > cmp_base);
  assign lost     = produced_count - cmp_base;
  assign can_read = (req_q == REQ_READ) && (consumed_count < produced_count);

  assign diff = produced_count - consumed_count;
  always_comb begin
    if (produced_count < consumed_count) begin
      unread = '0;
    end else if (diff > CNT_W'(RING_DEPTH)) begin
      unread = AVAIL_W'(RING_DEPTH);
    end else begin
      unread = diff[AVAIL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[producer_ptr] <= adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      ring_rdata <= ring_mem[consumer_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      producer_ptr   <= '0;
      seen_ptr       <= '0;
      consumer_ptr   <= '0;
      produced_count <= '0;
      consumed_count <= '0;
      overrun_flag   <= 1'b0;
      done           <= 1'b0;
      have_data      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_type;
            now_q <= now_ms;
            age_q <= age_calc;
            unique case (req_type)
              REQ_SAMPLE: begin
                producer_ptr <= producer_ptr + ptr_t'(1);
              end
              REQ_CLEAR: begin
                overrun_flag <= 1'b0;
              end
              default: begin
                produced_count <= produced_count + CNT_W'(ptr_delta);
                seen_ptr       <= producer_ptr;
                state          <= S_BASE;
              end
            endcase
          end
        end
        S_BASE: begin
          cmp_base <= consumed_count + CNT_W'(RING_DEPTH);
          state    <= S_SKIP;
        end
        S_SKIP: begin
          // lagging by more than a ring: keep only the newest ring unread
          if (skip) begin
            consumed_count <= produced_count - CNT_W'(RING_DEPTH);
            consumer_ptr   <= consumer_ptr + lost[PTR_W-1:0];
            overrun_flag   <= 1'b1;
          end
          state <= S_READ;
        end
        S_READ: begin
          have_data <= can_read;
          if (can_read) begin
            consumer_ptr   <= consumer_ptr + ptr_t'(1);
            consumed_count <= consumed_count + CNT_W'(1);
            ts_q           <= now_q - CNT_W'(age_q);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP) begin
      ok             <= have_data;
      sample_value   <= have_data ? ring_rdata : '0;
      sample_time_ms <= have_data ? ts_q : '0;
      avail_count    <= unread;
      write_index    <= producer_ptr;
      overflow       <= overrun_flag;
    end
  end

  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RESP))
    else $error("done without result assembly");

  a_avail_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (avail_count <= AVAIL_W'(RING_DEPTH)))
    else $error("avail_count above ring depth");

  a_skip_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP && skip) |=> overrun_flag)
    else $error("overrun skip did not latch flag");

  a_ok_has_data: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> $past(have_data))
    else $error("ok without a consumed sample");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives sample, read, poll and clear requests into the sample ring overrun
// tracker under random sender gaps. A scoreboard object mirrors the ring,
// pointers, counts and overrun flag and checks every result as done pulses.
// ----------------------------------------------------------------------------
module tb;
  import sro_pkg::*;

  typedef struct packed {
    logic    ok;
    sample_t value;
    cnt_t    stamp;
    avail_t  avail;
    ptr_t    widx;
    logic    ovf;
  } reply_t;

  class ring_tracker_model;
    sample_t ring [RING_DEPTH];
    ptr_t    wr_ptr;
    ptr_t    seen_ptr;
    ptr_t    rd_ptr;
    cnt_t    produced;
    cnt_t    consumed;
    logic    overrun;
    period_t period;
    reply_t  pending [$];
    int      errors;

    function new();
      wr_ptr   = '0;
      seen_ptr = '0;
      rd_ptr   = '0;
      produced = '0;
      consumed = '0;
      overrun  = 1'b0;
      period   = PERIOD_RESET;
      errors   = 0;
    endfunction

    // applies one accepted request and queues the reply it should produce
    function void accept_request(req_t req, sample_t adc, cnt_t now, rem_t rem);
      ptr_t   ptr_delta;
      cnt_t   lost;
      cnt_t   age;
      cnt_t   unread;
      reply_t r;
      if (req == REQ_SAMPLE) begin
        ring[wr_ptr] = adc;
        wr_ptr++;
      end else if (req == REQ_CLEAR) begin
        overrun = 1'b0;
      end else begin
        // a full lap between observations wraps to zero distance
        ptr_delta = wr_ptr - seen_ptr;
        produced += cnt_t'(ptr_delta);
        seen_ptr = wr_ptr;
        if (produced > consumed + cnt_t'(RING_DEPTH)) begin
          lost = produced - consumed - cnt_t'(RING_DEPTH);
          consumed += lost;
          rd_ptr += ptr_t'(lost);
          overrun = 1'b1;
        end
        r = '0;
        if (req == REQ_READ && consumed < produced) begin
          age = (rem == '0) ? '0 : (cnt_t'(rem) - cnt_t'(1)) * cnt_t'(period);
          r.ok    = 1'b1;
          r.value = ring[rd_ptr];
          r.stamp = now - age;
          rd_ptr++;
          consumed++;
        end
        unread = (produced >= consumed) ? produced - consumed : '0;
        if (unread > cnt_t'(RING_DEPTH))
          unread = cnt_t'(RING_DEPTH);
        r.avail = avail_t'(unread);
        r.widx  = wr_ptr;
        r.ovf   = overrun;
        pending.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0d, got %0d", name, expected, actual);
        errors++;
      end
    endfunction

    function void check_reply(logic ok_o, sample_t val_o, cnt_t ts_o, avail_t av_o,
                              ptr_t wi_o, logic ovf_o);
      reply_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("ok", 32'(e.ok), 32'(ok_o));
      compare_field("sample_value", 32'(e.value), 32'(val_o));
      compare_field("sample_time_ms", e.stamp, ts_o);
      compare_field("avail_count", 32'(e.avail), 32'(av_o));
      compare_field("write_index", 32'(e.widx), 32'(wi_o));
      compare_field("overflow", 32'(e.ovf), 32'(ovf_o));
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  req_t    req_type;
  sample_t adc_sample;
  cnt_t    now_ms;
  rem_t    batch_left;
  logic    cfg_we;
  period_t cfg_wdata;
  logic    done;
  logic    ok;
  sample_t sample_value;
  cnt_t    sample_time_ms;
  avail_t  avail_count;
  ptr_t    write_index;
  logic    overflow;

  ring_tracker_model tracker;

  sample_ring_overrun_tracker uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .adc_sample     (adc_sample),
    .now_ms         (now_ms),
    .batch_left     (batch_left),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .ok             (ok),
    .sample_value   (sample_value),
    .sample_time_ms (sample_time_ms),
    .avail_count    (avail_count),
    .write_index    (write_index),
    .overflow       (overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_reply(ok, sample_value, sample_time_ms, avail_count, write_index, overflow);
  end

  // returns at the edge where the request is taken; start stays high
  task automatic send_request(req_t req, sample_t adc, cnt_t now, rem_t rem);
    start      <= 1'b1;
    req_type   <= req;
    adc_sample <= adc;
    now_ms     <= now;
    batch_left <= rem;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.accept_request(req, adc, now, rem);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int sender_gap(bit dense);
    int r;
    r = $urandom_range(0, 99);
    if (dense || r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  function automatic rem_t read_remaining();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return '0;
    else if (r < 20)
      return rem_t'(1);
    else if (r < 30)
      return '1;
    else if (r < 70)
      return rem_t'($urandom_range(1, 32));
    else
      return rem_t'($urandom);
  endfunction

  task automatic send_samples(int n, bit dense);
    repeat (n) begin
      send_request(REQ_SAMPLE, sample_t'($urandom), cnt_t'($urandom), rem_t'($urandom));
      pause_sender(sender_gap(dense));
    end
  endtask

  task automatic send_read(bit dense);
    send_request(REQ_READ, sample_t'($urandom), cnt_t'($urandom), read_remaining());
    pause_sender(sender_gap(dense));
  endtask

  // hold off until every outstanding reply has come back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_period(period_t p);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.period = p;
  endtask

  task automatic run_random(int budget);
    int sent;
    int pick;
    int len;
    bit dense;
    sent  = 0;
    dense = 1'b0;
    while (sent < budget) begin
      if ($urandom_range(0, 19) == 0)
        dense = ~dense;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        len = $urandom_range(1, 8);
        send_samples(len, dense);
        sent += len;
      end else if (pick < 26) begin
        // long runs: overrun, or exactly one lap that goes uncounted
        len = ($urandom_range(0, 1) == 0) ? RING_DEPTH : $urandom_range(300, 620);
        send_samples(len, dense);
        sent += len;
      end else if (pick < 36) begin
        len = $urandom_range(2, 12);
        repeat (len) send_read(dense);
        sent += len;
      end else if (pick < 75) begin
        send_read(dense);
        sent++;
      end else if (pick < 93) begin
        send_request(REQ_POLL, sample_t'($urandom), cnt_t'($urandom), rem_t'($urandom));
        pause_sender(sender_gap(dense));
        sent++;
      end else begin
        send_request(REQ_CLEAR, sample_t'($urandom), cnt_t'($urandom), rem_t'($urandom));
        pause_sender(sender_gap(dense));
        sent++;
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    tracker    = new();
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    req_type   = REQ_SAMPLE;
    adc_sample = '0;
    now_ms     = '0;
    batch_left = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = PERIOD_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring, clear with no flag, field extremes, timestamp wrap
    send_request(REQ_READ, 12'd0, 32'd1000, 16'd1);
    send_request(REQ_POLL, 12'd0, 32'd0, 16'd0);
    send_request(REQ_CLEAR, 12'd0, 32'd0, 16'd0);
    send_request(REQ_SAMPLE, 12'd0, 32'd0, 16'd0);
    send_request(REQ_SAMPLE, 12'hfff, 32'hffff_ffff, 16'hffff);
    send_samples(3, 1'b1);
    send_request(REQ_POLL, 12'hfff, 32'hffff_ffff, 16'hffff);
    send_request(REQ_READ, 12'd0, 32'd0, 16'd0);
    send_request(REQ_READ, 12'd0, 32'hffff_ffff, 16'd1);
    send_request(REQ_READ, 12'd0, 32'h1234_5678, 16'hffff);
    send_request(REQ_READ, 12'hfff, 32'd0, 16'd2);
    send_request(REQ_READ, 12'd0, 32'd7, 16'd3);
    send_request(REQ_READ, 12'd0, 32'd7, 16'd3);
    pause_sender(3);

    // exactly one lap between polls adds nothing, then a read finds it empty
    send_samples(RING_DEPTH, 1'b0);
    send_request(REQ_POLL, 12'd0, 32'd0, 16'd0);
    send_read(1'b0);
    // two partial laps overrun the consumer, then the flag is cleared
    send_samples(300, 1'b0);
    send_request(REQ_POLL, 12'd0, 32'd0, 16'd0);
    send_samples(300, 1'b1);
    send_read(1'b0);
    send_request(REQ_POLL, 12'd0, 32'd0, 16'd0);
    send_request(REQ_CLEAR, 12'd0, 32'd0, 16'd0);
    send_request(REQ_POLL, 12'd0, 32'd0, 16'd0);
    send_read(1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0)
        set_period(8'd1);
      else if (ph == 1)
        set_period(8'd255);
      else
        set_period(period_t'($urandom_range(1, 255)));
      run_random(80);
    end

    drain();
    if (tracker.errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/sro_pkg.sv
rtl/sample_ring_overrun_tracker.sv
test/tb.sv
